### design/multichannel_adc_scan_averager_assert.svh
// Assertion macros for the checker file of the scan averager.
`ifndef MULTICHANNEL_ADC_SCAN_AVERAGER_ASSERT_SVH
`define MULTICHANNEL_ADC_SCAN_AVERAGER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scan averager assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scan averager assertion failed");

`endif

### design/msa_pkg.sv
package msa_pkg;

  localparam int SAMPLE_W  = 10;
  localparam int CHAN_W    = 3;
  localparam int MUX_W     = 5;
  localparam int TABLE_LEN = 8;
  localparam int COUNT_W   = 4;
  localparam int TABLE_W   = MUX_W * TABLE_LEN;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MUX_TABLE     = 1'b1;

  localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RESET = 4'd1;

  // One sample word in the queue between front and back, tagged with
  // whether it closes the averaging window.
  typedef struct packed {
    logic                last;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  // One result word.
  typedef struct packed {
    logic [MUX_W-1:0]    mux_select;
    logic                average_valid;
    logic [CHAN_W-1:0]   average_channel;
    logic [SAMPLE_W-1:0] average_value;
  } result_t;

  typedef struct packed {
    logic [COUNT_W-1:0] channel_count;
    logic [TABLE_W-1:0] mux_table;
  } cfg_t;

  function automatic logic [MUX_W-1:0] mux_code(input logic [TABLE_W-1:0] tbl,
                                                input logic [CHAN_W-1:0]  idx);
    mux_code = tbl[idx * MUX_W +: MUX_W];
  endfunction

endpackage

### design/msa_fifo.sv
module msa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/msa_front.sv
module msa_front import msa_pkg::*; #(
  parameter int SAMPLE_SHIFT = 4,
  parameter int DEPTH        = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                full,
  input  logic                q_pop,
  output item_t               q_item,
  output logic                q_empty
);

  localparam int CNT_W = SAMPLE_SHIFT + 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'((1 << SAMPLE_SHIFT) - 1);

  logic [CNT_W-1:0] sample_count;
  logic             accept;
  item_t            item;

  assign accept      = push && !full;
  assign item.last   = (sample_count == CNT_LAST);
  assign item.sample = sample;

  // The window position is known at the input, so the back end only has to
  // act on the tag.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
    end else if (accept) begin
      sample_count <= item.last ? '0 : sample_count + 1'b1;
    end
  end

  msa_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (item),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );

endmodule

### design/msa_back.sv
module msa_back import msa_pkg::*; #(
  parameter int SAMPLE_SHIFT = 4,
  parameter int MAX_CHANNELS = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  item_t   q_item,
  input  logic    q_empty,
  output logic    q_pop,
  input  logic    res_full,
  output logic    res_push,
  output result_t res
);

  localparam int ACC_W = SAMPLE_W + SAMPLE_SHIFT;
  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_CHANNELS);

  logic [ACC_W-1:0]   accumulator;
  logic [ACC_W-1:0]   sum;
  logic [CHAN_W-1:0]  channel_index;
  logic [CHAN_W-1:0]  channel_index_next;
  logic [CHAN_W-1:0]  index_after;
  logic [COUNT_W-1:0] index_inc;
  logic [COUNT_W-1:0] eff_count;

  assign q_pop    = !q_empty && !res_full;
  assign res_push = q_pop;
  assign sum      = accumulator + ACC_W'(q_item.sample);

  // A count of zero scans channel 0 only; a count above the limit is clamped.
  always_comb begin
    eff_count = cfg.channel_count;
    if (eff_count == '0) begin
      eff_count = COUNT_W'(1);
    end
    if (eff_count > MAX_COUNT) begin
      eff_count = MAX_COUNT;
    end
    index_inc          = {1'b0, channel_index} + 1'b1;
    channel_index_next = (index_inc >= eff_count) ? '0 : index_inc[CHAN_W-1:0];
    index_after        = q_item.last ? channel_index_next : channel_index;
  end

  always_comb begin
    res.mux_select      = mux_code(cfg.mux_table, index_after);
    res.average_valid   = q_item.last;
    res.average_channel = q_item.last ? channel_index : '0;
    res.average_value   = q_item.last ? sum[SAMPLE_SHIFT +: SAMPLE_W] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= '0;
      channel_index <= '0;
    end else if (q_pop) begin
      accumulator   <= q_item.last ? '0 : sum;
      channel_index <= index_after;
    end
  end

endmodule

### design/multichannel_adc_scan_averager.sv
// Channel   Ports                                   Handshake
// input     sample                                  push / full
// result    mux_select, average_valid,              empty / pop
//           average_channel, average_value
// config    cfg_index, cfg_data                     cfg_we
//
// One sample word is taken every cycle while full is low; each puts one result
// word on the result ports, registered first in the input queue and then in the
// result queue. The add and wrap of the channel index are combinational and
// do not hold back the flow.
// Reset clears the window count, the sum, the channel index and both queues,
// and loads channel_count with 1. When pop stays low the result queue fills,
// the back end stops draining, and full rises once the input queue is also full.
module multichannel_adc_scan_averager import msa_pkg::*; #(
  parameter int SAMPLE_SHIFT = 4,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [SAMPLE_W-1:0]  sample,
  output logic                 empty,
  input  logic                 pop,
  output logic [MUX_W-1:0]     mux_select,
  output logic                 average_valid,
  output logic [CHAN_W-1:0]    average_channel,
  output logic [SAMPLE_W-1:0]  average_value,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TABLE_W-1:0]   cfg_data
);

  localparam int QUEUE_DEPTH = 2;

  cfg_t    cfg;
  item_t   q_item;
  logic    q_empty;
  logic    q_pop;
  logic    res_full;
  logic    res_push;
  result_t res_in;
  result_t res_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_count <= CHANNEL_COUNT_RESET;
      cfg.mux_table     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHANNEL_COUNT: cfg.channel_count <= cfg_data[COUNT_W-1:0];
        REG_MUX_TABLE:     cfg.mux_table     <= cfg_data;
        default:           cfg               <= cfg;
      endcase
    end
  end

  msa_front #(
    .SAMPLE_SHIFT (SAMPLE_SHIFT),
    .DEPTH        (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .sample  (sample),
    .full    (full),
    .q_pop   (q_pop),
    .q_item  (q_item),
    .q_empty (q_empty)
  );

  msa_back #(
    .SAMPLE_SHIFT (SAMPLE_SHIFT),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_item   (q_item),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  msa_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign mux_select      = res_out.mux_select;
  assign average_valid   = res_out.average_valid;
  assign average_channel = res_out.average_channel;
  assign average_value   = res_out.average_value;

endmodule

### design/msa_checker.sv
`include "multichannel_adc_scan_averager_assert.svh"

module msa_checker import msa_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input logic [MUX_W-1:0]    mux_select,
  input logic                average_valid,
  input logic [CHAN_W-1:0]   average_channel,
  input logic [SAMPLE_W-1:0] average_value
);

  logic [MUX_W+CHAN_W+SAMPLE_W:0] result_word;
  logic                           avg_zero;

  assign result_word = {mux_select, average_valid, average_channel, average_value};
  assign avg_zero    = (average_channel == '0) && (average_value == '0);

  // Nothing is waiting on the result side right after reset.
  `MSA_ASSERT_NOW(a_empty_after_reset, $past(rst), empty)

  // A word that closes no window carries no channel and no average.
  `MSA_ASSERT_NOW(a_idle_fields_zero, !empty && !average_valid, avg_zero)

  // With the result side drained the back end keeps the input queue from filling.
  `MSA_ASSERT_NOW(a_not_full_when_empty, empty, !full)

  // A waiting word that is not taken stays as it is.
  `MSA_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(result_word))

endmodule

bind multichannel_adc_scan_averager msa_checker u_checker (.*);
